@@ hw/rtl/skc_pkg.sv @@
package skc_pkg;

  typedef struct packed {
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    logic       in_region;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } result_t;

  // Pixel data carried alongside the arithmetic through the pipeline.
  typedef struct packed {
    logic [7:0] fg_red;
    logic [7:0] fg_green;
    logic [7:0] fg_blue;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
    logic       bypass;
  } side_t;

  typedef enum logic [2:0] {
    REG_KEY_RED         = 3'd0,
    REG_KEY_GREEN       = 3'd1,
    REG_KEY_BLUE        = 3'd2,
    REG_KEY_CHROMA_BLUE = 3'd3,
    REG_KEY_CHROMA_RED  = 3'd4,
    REG_TOL_LOW         = 3'd5,
    REG_TOL_HIGH        = 3'd6
  } cfg_reg_t;

  localparam int D2_W       = 19;
  localparam int ROOT_W     = 18;
  localparam int SQRT_STEPS = 18;
  localparam int RADICAND_W = 2 * SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 2;

  localparam int          CHROMA_X_W = 28;
  localparam logic [28:0] RECIP_MILLION = 29'd281474977;
  localparam int          RECIP_SHIFT = 48;

endpackage

@@ hw/rtl/skc_sqrt_pipe.sv @@
module skc_sqrt_pipe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [skc_pkg::D2_W-1:0]     d2,
  input  skc_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [skc_pkg::ROOT_W-1:0]   root,
  output skc_pkg::side_t               out_side
);
  import skc_pkg::*;

  logic                  v   [0:SQRT_STEPS];
  logic [RADICAND_W-1:0] n   [0:SQRT_STEPS];
  logic [REM_W-1:0]      rem [0:SQRT_STEPS];
  logic [ROOT_W-1:0]     rt  [0:SQRT_STEPS];
  side_t                 sd  [0:SQRT_STEPS];

  assign v[0]   = in_valid;
  assign n[0]   = {{(RADICAND_W - D2_W - 16){1'b0}}, d2, 16'b0};
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             take;

    assign rem_sh = {rem[i], n[i][RADICAND_W-1-2*i -: 2]};
    assign trial  = {2'b00, rt[i], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
      n[i+1]  <= n[i];
      sd[i+1] <= sd[i];
      if (take) begin
        rem[i+1] <= REM_W'(rem_sh - trial);
        rt[i+1]  <= {rt[i][ROOT_W-2:0], 1'b1};
      end else begin
        rem[i+1] <= rem_sh[REM_W-1:0];
        rt[i+1]  <= {rt[i][ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v[SQRT_STEPS];
  assign root      = rt[SQRT_STEPS];
  assign out_side  = sd[SQRT_STEPS];

endmodule

@@ hw/rtl/soft_chroma_key_compositor.sv @@
// Soft chroma key compositor, one foreground/background pixel pair per request.
// A request is taken at a rising edge with start high and busy low. busy is low
// at all times except during reset, so a new request may be issued every cycle.
// The result appears on result for exactly one cycle with result_valid high, in request order.
// The depth is set by the chroma reciprocal multiply, an 18-stage square root
// pipeline with one root bit per stage, a WEIGHT_FRAC_BITS-step restoring divider
// for the soft weight and the blend multiply and saturate stages.
// Key and tolerance registers are written through cfg_valid/cfg_ready with a
// register index and data; cfg_ready is always high and writes are meant to
// happen while no request is in flight. Unknown indexes are ignored.
// Synchronous reset empties the pipeline, drops any request in flight and
// restores the register reset values. The receiver cannot stall the output.
module soft_chroma_key_compositor #(
  parameter int WEIGHT_FRAC_BITS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  skc_pkg::pixel_t  pixel,
  output logic             result_valid,
  output skc_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [8:0]       cfg_data
);
  import skc_pkg::*;

  localparam int F   = WEIGHT_FRAC_BITS;
  localparam int LAT = 4 + SQRT_STEPS + 4 + F;
  localparam logic [F:0] WONE = {1'b1, {F{1'b0}}};

  typedef enum logic [1:0] {W_ZERO, W_RAMP, W_ONE} wsel_t;

  logic [7:0] key_red, key_green, key_blue;
  logic [8:0] key_chroma_blue, key_chroma_red, tol_low, tol_high;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_red         <= '0;
      key_green       <= '0;
      key_blue        <= '0;
      key_chroma_blue <= '0;
      key_chroma_red  <= '0;
      tol_low         <= 9'd2;
      tol_high        <= 9'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_RED:         key_red         <= cfg_data[7:0];
        REG_KEY_GREEN:       key_green       <= cfg_data[7:0];
        REG_KEY_BLUE:        key_blue        <= cfg_data[7:0];
        REG_KEY_CHROMA_BLUE: key_chroma_blue <= cfg_data;
        REG_KEY_CHROMA_RED:  key_chroma_red  <= cfg_data;
        REG_TOL_LOW:         tol_low         <= cfg_data;
        REG_TOL_HIGH:        tol_high        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: chroma scaled by one million, with the rounding offset added.
  logic                  s1_valid;
  logic [CHROMA_X_W-1:0] s1_xcb, s1_xcr;
  side_t                 s1_side;
  logic signed [31:0]    xcb, xcr;
  logic signed [31:0]    r_s, g_s, b_s;

  assign r_s = 32'(pixel.fg_red);
  assign g_s = 32'(pixel.fg_green);
  assign b_s = 32'(pixel.fg_blue);
  assign xcb = 32'sd128500000 - 32'sd168736 * r_s - 32'sd331264 * g_s + 32'sd500000 * b_s;
  assign xcr = 32'sd128500000 + 32'sd500000 * r_s - 32'sd418688 * g_s - 32'sd81312 * b_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_xcb  <= xcb[CHROMA_X_W-1:0];
    s1_xcr  <= xcr[CHROMA_X_W-1:0];
    s1_side <= '{fg_red: pixel.fg_red, fg_green: pixel.fg_green, fg_blue: pixel.fg_blue,
                 bg_red: pixel.bg_red, bg_green: pixel.bg_green, bg_blue: pixel.bg_blue,
                 bypass: !pixel.in_region || (key_chroma_blue == 9'd0)};
  end

  // Stage 2: divide by one million through a reciprocal multiply.
  logic        s2_valid;
  logic [8:0]  s2_cb, s2_cr;
  side_t       s2_side;
  logic [56:0] pcb, pcr;

  assign pcb = 57'(s1_xcb) * 57'(RECIP_MILLION);
  assign pcr = 57'(s1_xcr) * 57'(RECIP_MILLION);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_cb   <= pcb[RECIP_SHIFT+8:RECIP_SHIFT];
    s2_cr   <= pcr[RECIP_SHIFT+8:RECIP_SHIFT];
    s2_side <= s1_side;
  end

  // Stage 3: squared chroma differences.
  logic               s3_valid;
  logic [17:0]        s3_sqb, s3_sqr;
  side_t              s3_side;
  logic signed [10:0] dcb, dcr;
  logic signed [21:0] sqb, sqr;

  assign dcb = $signed({2'b00, key_chroma_blue}) - $signed({2'b00, s2_cb});
  assign dcr = $signed({2'b00, key_chroma_red}) - $signed({2'b00, s2_cr});
  assign sqb = dcb * dcb;
  assign sqr = dcr * dcr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_sqb  <= sqb[17:0];
    s3_sqr  <= sqr[17:0];
    s3_side <= s2_side;
  end

  // Stage 4: squared distance.
  logic            s4_valid;
  logic [D2_W-1:0] s4_d2;
  side_t           s4_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_d2   <= D2_W'(s3_sqb) + D2_W'(s3_sqr);
    s4_side <= s3_side;
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  side_t             sq_side;

  skc_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_valid),
    .d2        (s4_d2),
    .in_side   (s4_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  // Stage 5: tolerance compare and divider operands.
  logic        s5_valid;
  wsel_t       s5_sel;
  logic [16:0] s5_num, s5_den;
  side_t       s5_side;
  logic [16:0] lo, hi;

  assign lo = {tol_low, 8'b0};
  assign hi = {tol_high, 8'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= sq_valid;
    end
    if (sq_root < ROOT_W'(lo)) begin
      s5_sel <= W_ZERO;
    end else if (sq_root < ROOT_W'(hi)) begin
      s5_sel <= W_RAMP;
    end else begin
      s5_sel <= W_ONE;
    end
    s5_num  <= 17'(sq_root - ROOT_W'(lo));
    s5_den  <= hi - lo;
    s5_side <= sq_side;
  end

  // Restoring divider, one quotient bit per stage.
  logic        dv_valid [0:F];
  wsel_t       dv_sel   [0:F];
  logic [16:0] dv_rem   [0:F];
  logic [16:0] dv_den   [0:F];
  logic [F-1:0] dv_q    [0:F];
  side_t       dv_side  [0:F];

  assign dv_valid[0] = s5_valid;
  assign dv_sel[0]   = s5_sel;
  assign dv_rem[0]   = s5_num;
  assign dv_den[0]   = s5_den;
  assign dv_q[0]     = '0;
  assign dv_side[0]  = s5_side;

  for (genvar i = 0; i < F; i++) begin : g_div
    logic [17:0] rsh;
    logic        take;

    assign rsh  = {dv_rem[i], 1'b0};
    assign take = rsh >= {1'b0, dv_den[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i+1] <= 1'b0;
      end else begin
        dv_valid[i+1] <= dv_valid[i];
      end
      dv_sel[i+1]  <= dv_sel[i];
      dv_den[i+1]  <= dv_den[i];
      dv_side[i+1] <= dv_side[i];
      dv_q[i+1]    <= {dv_q[i][F-2:0], take};
      dv_rem[i+1]  <= take ? 17'(rsh - {1'b0, dv_den[i]}) : rsh[16:0];
    end
  end

  // Stage A: complement of the weight.
  logic       sa_valid;
  logic [F:0] sa_a;
  side_t      sa_side;
  logic [F:0] w;

  always_comb begin
    case (dv_sel[F])
      W_ZERO:  w = '0;
      W_RAMP:  w = {1'b0, dv_q[F]};
      W_ONE:   w = WONE;
      default: w = WONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else begin
      sa_valid <= dv_valid[F];
    end
    sa_a    <= WONE - w;
    sa_side <= dv_side[F];
  end

  // Stage M: blend products.
  localparam int PW = F + 9;
  logic          sm_valid;
  logic [PW-1:0] sm_sub [0:2];
  logic [PW-1:0] sm_add [0:2];
  side_t         sm_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_valid <= 1'b0;
    end else begin
      sm_valid <= sa_valid;
    end
    sm_sub[0] <= PW'(sa_a) * PW'(key_red);
    sm_sub[1] <= PW'(sa_a) * PW'(key_green);
    sm_sub[2] <= PW'(sa_a) * PW'(key_blue);
    sm_add[0] <= PW'(sa_a) * PW'(sa_side.bg_red);
    sm_add[1] <= PW'(sa_a) * PW'(sa_side.bg_green);
    sm_add[2] <= PW'(sa_a) * PW'(sa_side.bg_blue);
    sm_side   <= sa_side;
  end

  // Stage O: clamp, sum, saturate.
  logic [7:0] fgc [0:2];
  logic [7:0] bl  [0:2];

  assign fgc[0] = sm_side.fg_red;
  assign fgc[1] = sm_side.fg_green;
  assign fgc[2] = sm_side.fg_blue;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [PW-1:0] fgs;
    logic [PW-1:0] diff;
    logic [PW:0]   v;

    assign fgs  = {1'b0, fgc[c], {F{1'b0}}};
    assign diff = (fgs > sm_sub[c]) ? fgs - sm_sub[c] : '0;
    assign v    = {1'b0, diff} + {1'b0, sm_add[c]};
    assign bl[c] = (v[PW:F] > (PW + 1 - F)'(255)) ? 8'd255 : v[F+7:F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= sm_valid;
    end
    if (sm_side.bypass) begin
      result <= '{out_red: fgc[0], out_green: fgc[1], out_blue: fgc[2]};
    end else begin
      result <= '{out_red: bl[0], out_green: bl[1], out_blue: bl[2]};
    end
  end

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT result_valid)
    else $error("request did not produce a result at the pipeline latency");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    result_valid && $past(start && !busy && !pixel.in_region, LAT) |->
      result.out_red == $past(pixel.fg_red, LAT) &&
      result.out_green == $past(pixel.fg_green, LAT) &&
      result.out_blue == $past(pixel.fg_blue, LAT))
    else $error("pixel outside the region was not passed through");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    dv_valid[F] && dv_sel[F] == W_RAMP |-> dv_rem[F] < dv_den[F])
    else $error("divider remainder not below divisor");
`endif

endmodule
